@@ src/tes_pkg.sv @@
`timescale 1ns / 1ps
// tes_pkg: shared types and constants of the timed event scheduler.
// Depends on nothing; the top level, tes_ctrl and tes_alu import it.
package tes_pkg;

	localparam int NUM_EVENTS_DEF = 16;
	localparam int MAX_FIRES_DEF  = 32;
	localparam int TIME_W         = 64;
	localparam int PER_W          = 32;
	localparam int SLOT_W         = 4;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	typedef enum logic [1:0] {
		OP_ADD     = 2'd0,
		OP_CANCEL  = 2'd1,
		OP_PROCESS = 2'd2,
		OP_NOP     = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_CANCEL = 2'd1,
		KIND_FIRE   = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef struct packed {
		opcode_t             opcode;
		logic [TIME_W-1:0]   due_time;
		logic                repeat_flag;
		logic [PER_W-1:0]    period;
		logic [SLOT_W-1:0]   handle;
		logic [TIME_W-1:0]   current_time;
	} cmd_t;

	typedef struct packed {
		kind_t               kind;
		logic [SLOT_W-1:0]   slot;
		logic [TIME_W-1:0]   fire_time;
		logic [TIME_W-1:0]   next_due;
		logic                ok;
		logic                last;
		logic                more_due;
	} res_t;

	// result offered by the sequencer to the output register
	typedef struct packed {
		logic req;
		res_t item;
	} push_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_SCAN,
		ST_ADD_WR,
		ST_CANCEL,
		ST_SCAN,
		ST_DECIDE,
		ST_FIRE_RD,
		ST_FIRE_ADD,
		ST_FIRE_MIN,
		ST_CAP
	} state_t;

endpackage

@@ src/timed_event_scheduler.sv @@
`timescale 1ns / 1ps
// timed_event_scheduler: top level, output register around the sequencer.
// Depends on tes_pkg and tes_ctrl (which holds tes_alu and two tes_ram).
//
//   channel  signals                         payload
//   cmd      cmd_valid / cmd_ready / cmd     tes_pkg::cmd_t (opcode ... current_time)
//   res      res_valid / res_ready / res     tes_pkg::res_t (kind ... more_due)
//
// Flow: one item at a time; cmd_ready is high only while the sequencer idles.
// Add walks the active flags one slot a cycle. Process runs one table scan
// per round through the due RAM and the shared compare unit, then decides
// and fires (period read, add and, for a repeating event, a new minimum);
// when the fire cap is hit the closing scan only flags whether more events
// are due and finds the earliest due time instead of picking another.
// Reset clears the active flags and sets the earliest due time to all ones;
// the table RAMs are not cleared. A stalled res side holds the sequencer
// only when it has a new result to hand over.
module timed_event_scheduler #(
	parameter int NUM_EVENTS = tes_pkg::NUM_EVENTS_DEF,
	parameter int MAX_FIRES  = tes_pkg::MAX_FIRES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  tes_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output tes_pkg::res_t res
);
	import tes_pkg::*;

	push_t push;
	logic  push_gnt;
	logic  res_valid_q;
	res_t  res_q;

	tes_ctrl #(
		.NUM_EVENTS (NUM_EVENTS),
		.MAX_FIRES  (MAX_FIRES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.push      (push),
		.push_gnt  (push_gnt)
	);

	// take a new result when the register is empty or being drained this cycle
	assign push_gnt = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (push.req && push_gnt) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// hold the payload until taken
	always_ff @(posedge clk) begin
		if (push.req && push_gnt) begin
			res_q <= push.item;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTH
	// only fires carry a fire time and the more-due flag
	a_fire_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.kind != KIND_FIRE) |-> (res.fire_time == '0) && !res.more_due)
		else $error("non-fire result carries fire fields");

	// add, cancel and nothing-due each end their item at once
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.kind != KIND_FIRE) |-> res.last)
		else $error("single result item not marked last");

	// a nothing-due result is slot zero and ok
	a_none_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.kind == KIND_NONE) |-> (res.slot == '0) && res.ok)
		else $error("nothing-due result has bad fields");

	// every fire result reports ok
	a_fire_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.kind == KIND_FIRE) |-> res.ok)
		else $error("fire result without ok");
`endif

endmodule

@@ src/tes_ram.sv @@
`timescale 1ns / 1ps
// tes_ram: generic single write port, single read port RAM, registered read.
// Depends on nothing.
module tes_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/tes_alu.sv @@
`timescale 1ns / 1ps
// tes_alu: the shared compare and add unit used by the add, scan and fire steps.
// Depends on tes_pkg.
module tes_alu (
	input  logic [tes_pkg::TIME_W-1:0] a,
	input  logic [tes_pkg::TIME_W-1:0] now,
	input  logic [tes_pkg::TIME_W-1:0] r0,
	input  logic [tes_pkg::TIME_W-1:0] r1,
	input  logic [tes_pkg::PER_W-1:0]  addend,
	output logic                       le_now,
	output logic                       lt_r0,
	output logic                       lt_r1,
	output logic [tes_pkg::TIME_W-1:0] sum
);
	import tes_pkg::*;

	// three independent compares side by side, one add; wrap modulo 2^64
	assign le_now = (a <= now);
	assign lt_r0  = (a < r0);
	assign lt_r1  = (a < r1);
	assign sum    = a + TIME_W'(addend);

endmodule

@@ src/tes_ctrl.sv @@
`timescale 1ns / 1ps
// tes_ctrl: sequencer, active flags, event table RAMs and scan accumulators.
// Depends on tes_pkg, tes_ram and tes_alu.
module tes_ctrl #(
	parameter int NUM_EVENTS = tes_pkg::NUM_EVENTS_DEF,
	parameter int MAX_FIRES  = tes_pkg::MAX_FIRES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  tes_pkg::cmd_t  cmd,
	output tes_pkg::push_t push,
	input  logic           push_gnt
);
	import tes_pkg::*;

	localparam int SW = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
	localparam int CW = $clog2(NUM_EVENTS + 1);
	localparam int FW = (MAX_FIRES > 1) ? $clog2(MAX_FIRES) : 1;
	localparam int HW = (SW > SLOT_W) ? SW : SLOT_W;

	state_t              state_q, state_d;
	cmd_t                cmd_q;
	logic [CW-1:0]       cnt_q;
	logic [SW-1:0]       cnt_idx;
	logic                cnt_full;
	logic                rd_vld_s1;
	logic [SW-1:0]       rd_idx_s1;
	logic                rd_act_s1;
	logic [NUM_EVENTS-1:0] active_q;
	logic [TIME_W-1:0]   earliest_q;
	logic                pick_vld_q;
	logic [SW-1:0]       pick_q;
	logic [TIME_W-1:0]   best_q;
	logic [TIME_W-1:0]   min_q;
	logic                more_q;
	logic [FW-1:0]       fired_q;
	logic                hold_vld_q;
	res_t                hold_q;
	logic [TIME_W-1:0]   new_due_q;

	// sequencer controls
	logic                scan_start, cnt_clr, cnt_inc, add_pick, proc_start;
	logic                act_set, act_clr;
	logic [SW-1:0]       act_idx;
	logic                ear_ld;
	logic [TIME_W-1:0]   ear_d;
	logic                hold_ld, hold_clr, fired_inc, new_due_ld;
	res_t                hold_d;
	logic                scanning, scan_issue, scan_done, acc;

	// table RAM ports
	logic                due_we, per_we, per_re;
	logic [TIME_W-1:0]   due_wdata, due_rdata;
	logic [PER_W:0]      per_rdata;

	// shared unit
	logic [TIME_W-1:0]   alu_a, alu_r1, alu_sum;
	logic                le_now, lt_r0, lt_r1;

	// cancel decode
	logic [HW-1:0]       h_ext;
	logic [SW-1:0]       h_idx;
	logic                h_in_range;
	logic                add_bad;
	logic [TIME_W-1:0]   add_nd;
	logic                last_fire;

	assign cnt_idx    = cnt_q[SW-1:0];
	assign cnt_full   = (cnt_q == CW'(NUM_EVENTS));
	assign scanning   = (state_q == ST_SCAN) || (state_q == ST_CAP);
	assign scan_issue = scanning && !cnt_full;
	assign scan_done  = cnt_full && !rd_vld_s1;
	assign acc        = rd_vld_s1 && rd_act_s1;

	assign h_ext      = HW'(cmd_q.handle);
	assign h_idx      = h_ext[SW-1:0];
	assign h_in_range = (32'(cmd_q.handle) < 32'(NUM_EVENTS));
	assign add_bad    = cmd_q.repeat_flag && (cmd_q.period == '0);
	assign add_nd     = lt_r1 ? cmd_q.due_time : earliest_q;
	assign last_fire  = (fired_q == FW'(MAX_FIRES - 1));

	always_comb begin
		unique case (state_q)
			ST_ADD_WR:   alu_a = cmd_q.due_time;
			ST_FIRE_ADD: alu_a = best_q;
			ST_FIRE_MIN: alu_a = new_due_q;
			default:     alu_a = due_rdata;
		endcase
	end

	assign alu_r1    = (state_q == ST_ADD_WR) ? earliest_q : min_q;
	assign due_wdata = (state_q == ST_ADD_WR) ? cmd_q.due_time : alu_sum;

	tes_alu u_alu (
		.a      (alu_a),
		.now    (cmd_q.current_time),
		.r0     (best_q),
		.r1     (alu_r1),
		.addend (per_rdata[PER_W-1:0]),
		.le_now (le_now),
		.lt_r0  (lt_r0),
		.lt_r1  (lt_r1),
		.sum    (alu_sum)
	);

	tes_ram #(.WIDTH(TIME_W), .DEPTH(NUM_EVENTS)) u_due_ram (
		.clk   (clk),
		.we    (due_we),
		.waddr (pick_q),
		.wdata (due_wdata),
		.re    (scan_issue),
		.raddr (cnt_idx),
		.rdata (due_rdata)
	);

	tes_ram #(.WIDTH(PER_W + 1), .DEPTH(NUM_EVENTS)) u_per_ram (
		.clk   (clk),
		.we    (per_we),
		.waddr (pick_q),
		.wdata ({cmd_q.repeat_flag, cmd_q.period}),
		.re    (per_re),
		.raddr (pick_q),
		.rdata (per_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd_ready  = 1'b0;
		push       = '0;
		scan_start = 1'b0;
		cnt_clr    = 1'b0;
		cnt_inc    = 1'b0;
		add_pick   = 1'b0;
		proc_start = 1'b0;
		act_set    = 1'b0;
		act_clr    = 1'b0;
		act_idx    = pick_q;
		ear_ld     = 1'b0;
		ear_d      = min_q;
		hold_ld    = 1'b0;
		hold_clr   = 1'b0;
		hold_d     = hold_q;
		fired_inc  = 1'b0;
		new_due_ld = 1'b0;
		due_we     = 1'b0;
		per_we     = 1'b0;
		per_re     = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					unique case (cmd.opcode)
						OP_ADD: begin
							cnt_clr = 1'b1;
							state_d = ST_ADD_SCAN;
						end
						OP_CANCEL: state_d = ST_CANCEL;
						OP_PROCESS: begin
							scan_start = 1'b1;
							proc_start = 1'b1;
							state_d    = ST_SCAN;
						end
						OP_NOP: state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD_SCAN: begin
				if (add_bad || cnt_full) begin
					push.req  = 1'b1;
					push.item = '{kind: KIND_ADD, slot: '0, fire_time: '0,
						next_due: earliest_q, ok: 1'b0, last: 1'b1, more_due: 1'b0};
					if (push_gnt) begin
						state_d = ST_IDLE;
					end
				end else if (!active_q[cnt_idx]) begin
					add_pick = 1'b1;
					state_d  = ST_ADD_WR;
				end else begin
					cnt_inc = 1'b1;
				end
			end
			ST_ADD_WR: begin
				push.req  = 1'b1;
				push.item = '{kind: KIND_ADD, slot: SLOT_W'(pick_q), fire_time: '0,
					next_due: add_nd, ok: 1'b1, last: 1'b1, more_due: 1'b0};
				if (push_gnt) begin
					due_we  = 1'b1;
					per_we  = 1'b1;
					act_set = 1'b1;
					ear_ld  = 1'b1;
					ear_d   = add_nd;
					state_d = ST_IDLE;
				end
			end
			ST_CANCEL: begin
				push.req  = 1'b1;
				push.item = '{kind: KIND_CANCEL, slot: cmd_q.handle, fire_time: '0,
					next_due: earliest_q, ok: h_in_range && active_q[h_idx],
					last: 1'b1, more_due: 1'b0};
				if (push_gnt) begin
					act_clr = h_in_range;
					act_idx = h_idx;
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				ear_ld = 1'b1;
				ear_d  = min_q;
				if (pick_vld_q) begin
					if (hold_vld_q) begin
						// another fire follows, so the held one is not the last
						push.req  = 1'b1;
						push.item = hold_q;
						if (push_gnt) begin
							hold_clr = 1'b1;
							state_d  = ST_FIRE_RD;
						end
					end else begin
						state_d = ST_FIRE_RD;
					end
				end else begin
					push.req = 1'b1;
					if (hold_vld_q) begin
						push.item      = hold_q;
						push.item.last = 1'b1;
					end else begin
						push.item = '{kind: KIND_NONE, slot: '0, fire_time: '0,
							next_due: min_q, ok: 1'b1, last: 1'b1, more_due: 1'b0};
					end
					if (push_gnt) begin
						hold_clr = 1'b1;
						state_d  = ST_IDLE;
					end
				end
			end
			ST_FIRE_RD: begin
				per_re  = 1'b1;
				state_d = ST_FIRE_ADD;
			end
			ST_FIRE_ADD: begin
				if (per_rdata[PER_W]) begin
					due_we     = 1'b1;
					new_due_ld = 1'b1;
					state_d    = ST_FIRE_MIN;
				end else begin
					act_clr    = 1'b1;
					hold_ld    = 1'b1;
					hold_d     = '{kind: KIND_FIRE, slot: SLOT_W'(pick_q),
						fire_time: best_q, next_due: earliest_q, ok: 1'b1,
						last: 1'b0, more_due: 1'b0};
					fired_inc  = 1'b1;
					scan_start = 1'b1;
					state_d    = last_fire ? ST_CAP : ST_SCAN;
				end
			end
			ST_FIRE_MIN: begin
				ear_ld     = 1'b1;
				ear_d      = lt_r1 ? new_due_q : min_q;
				hold_ld    = 1'b1;
				hold_d     = '{kind: KIND_FIRE, slot: SLOT_W'(pick_q),
					fire_time: best_q, next_due: ear_d, ok: 1'b1,
					last: 1'b0, more_due: 1'b0};
				fired_inc  = 1'b1;
				scan_start = 1'b1;
				state_d    = last_fire ? ST_CAP : ST_SCAN;
			end
			ST_CAP: begin
				if (scan_done) begin
					push.req           = 1'b1;
					push.item          = hold_q;
					push.item.next_due = min_q;
					push.item.last     = 1'b1;
					push.item.more_due = more_q;
					if (push_gnt) begin
						ear_ld   = 1'b1;
						ear_d    = min_q;
						hold_clr = 1'b1;
						state_d  = ST_IDLE;
					end
				end
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= '0;
			earliest_q <= TIME_MAX;
			rd_vld_s1  <= 1'b0;
			pick_vld_q <= 1'b0;
			hold_vld_q <= 1'b0;
			cnt_q      <= '0;
			fired_q    <= '0;
		end else begin
			if (act_set) begin
				active_q[pick_q] <= 1'b1;
			end
			if (act_clr) begin
				active_q[act_idx] <= 1'b0;
			end
			if (ear_ld) begin
				earliest_q <= ear_d;
			end
			rd_vld_s1 <= scan_issue;
			if (scan_start || cnt_clr) begin
				cnt_q <= '0;
			end else if (scan_issue || cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (scan_start) begin
				pick_vld_q <= 1'b0;
			end else if (state_q == ST_SCAN && acc && le_now && (!pick_vld_q || lt_r0)) begin
				pick_vld_q <= 1'b1;
			end
			if (hold_ld) begin
				hold_vld_q <= 1'b1;
			end else if (hold_clr) begin
				hold_vld_q <= 1'b0;
			end
			if (proc_start) begin
				fired_q <= '0;
			end else if (fired_inc) begin
				fired_q <= fired_q + 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_q <= cmd;
		end
		rd_idx_s1 <= cnt_idx;
		rd_act_s1 <= active_q[cnt_idx];
		if (add_pick) begin
			pick_q <= cnt_idx;
		end
		if (hold_ld) begin
			hold_q <= hold_d;
		end
		if (new_due_ld) begin
			new_due_q <= alu_sum;
		end
		if (scan_start) begin
			min_q  <= TIME_MAX;
			more_q <= 1'b0;
		end else if (acc) begin
			if (state_q == ST_SCAN) begin
				if (le_now) begin
					if (!pick_vld_q || lt_r0) begin
						pick_q <= rd_idx_s1;
						best_q <= due_rdata;
					end
				end else if (lt_r1) begin
					min_q <= due_rdata;
				end
			end else begin
				if (le_now) begin
					more_q <= 1'b1;
				end
				if (lt_r1) begin
					min_q <= due_rdata;
				end
			end
		end
	end

endmodule
